// ===== sv/sorted_group_sum_count_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted group sum and count block
// Shorthand for the concurrent checks written at the end of the accumulator and result queue modules.
// ----------------------------------------------------------------------------
`ifndef SORTED_GROUP_SUM_COUNT_MACROS_SVH
`define SORTED_GROUP_SUM_COUNT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define SGSC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sgsc invariant violated");

// Whenever the condition holds, the consequence holds in the same cycle.
`define SGSC_ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("sgsc implication violated");

`endif

// ===== sv/sgsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsc_pkg
// Shared types and constants of the sorted group sum and count block.
// ----------------------------------------------------------------------------
package sgsc_pkg;

   localparam int KEY_BITS        = 63;
   localparam int PRICE_BITS      = 32;
   localparam int PCT_BITS        = 7;
   localparam int TERM_BITS       = PRICE_BITS + PCT_BITS;
   localparam int GROUP_SUM_BITS  = 48;
   localparam int GROUP_CNT_BITS  = 32;
   localparam int SUM_BITS_DEF    = 48;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int FIFO_DEPTH      = 4;

   localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

   // One registered record: key, weighted amount and the end-of-data mark.
   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [TERM_BITS-1:0] term;
      logic                 closes;
   } stage_type;

   // One finished group as it leaves the block.
   typedef struct packed {
      logic [KEY_BITS-1:0]       key;
      logic [GROUP_SUM_BITS-1:0] sum;
      logic [GROUP_CNT_BITS-1:0] count;
      logic                      overflow;
      logic                      last;
   } result_type;

   // Up to two results written into the output queue in one cycle.
   typedef struct packed {
      logic [1:0] words;
      result_type word0;
      result_type word1;
   } push_type;

endpackage

// ===== sv/sgsc_input_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgsc_input_stage
// Input register: captures a record and its price times remaining percentage.
// ----------------------------------------------------------------------------
module sgsc_input_stage
   import sgsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire logic [KEY_BITS-1:0]   in_key,
   input  wire logic [PRICE_BITS-1:0] in_price,
   input  wire logic [PCT_BITS-1:0]   in_discount,
   input  wire logic                  in_closes,
   input  wire logic                  take,
   output      logic                  stage_valid,
   output      stage_type             stage_data
);

   logic                valid_ff, valid_in;
   stage_type           data_ff, data_in;
   logic [PCT_BITS-1:0] disc_clamped;
   logic [PCT_BITS-1:0] factor;
   logic                load;

   assign in_ready = !valid_ff || take;
   assign load     = in_valid && in_ready;

   always_comb begin
      // A discount beyond a hundred percent counts as a full discount.
      disc_clamped = (in_discount > PCT_FULL) ? PCT_FULL : in_discount;
      factor       = PCT_FULL - disc_clamped;
      data_in.key    = in_key;
      data_in.term   = TERM_BITS'({{PCT_BITS{1'b0}}, in_price}
                                  * {{PRICE_BITS{1'b0}}, factor});
      data_in.closes = in_closes;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule
`default_nettype wire

// ===== sv/sgsc_accumulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgsc_accumulator
// Open-group state, saturating sum and count, and result word generation.
// ----------------------------------------------------------------------------
module sgsc_accumulator
   import sgsc_pkg::*;
#(
   parameter int SUM_BITS   = SUM_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      stage_valid,
   input  wire stage_type stage_data,
   input  wire logic      room,
   output      logic      take,
   output      push_type  push
);

`include "sorted_group_sum_count_macros.svh"

   localparam int SUM_OUT_W = (SUM_BITS > GROUP_SUM_BITS) ? SUM_BITS : GROUP_SUM_BITS;
   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic                  open_ff, open_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  sat_ff, sat_in;

   logic                  close_old;
   logic                  fresh;
   logic [SUM_BITS-1:0]   base_sum;
   logic [COUNT_BITS-1:0] base_count;
   logic                  base_sat;
   logic [SUM_BITS:0]     sum_wide;
   logic [SUM_BITS-1:0]   new_sum;
   logic [COUNT_BITS-1:0] new_count;
   logic                  new_sat;
   result_type            old_res, new_res;

   function automatic result_type make_result(
      input logic [KEY_BITS-1:0]   k,
      input logic [SUM_BITS-1:0]   s,
      input logic [COUNT_BITS-1:0] c,
      input logic                  o,
      input logic                  l
   );
      result_type             r;
      logic [SUM_OUT_W-1:0]   s_ext;
      s_ext      = SUM_OUT_W'(s);
      r.key      = k;
      r.sum      = s_ext[GROUP_SUM_BITS-1:0];
      r.count    = GROUP_CNT_BITS'(c);
      r.overflow = o;
      r.last     = l;
      return r;
   endfunction

   assign take = stage_valid && room;

   always_comb begin
      close_old  = open_ff && (stage_data.key != key_ff);
      fresh      = close_old || !open_ff;
      base_sum   = fresh ? '0 : sum_ff;
      base_count = fresh ? '0 : count_ff;
      base_sat   = fresh ? 1'b0 : sat_ff;

      sum_wide = {1'b0, base_sum} + (SUM_BITS+1)'(stage_data.term);
      new_sat  = base_sat;
      if (sum_wide[SUM_BITS]) begin
         new_sum = SUM_MAX;
         new_sat = 1'b1;
      end else begin
         new_sum = sum_wide[SUM_BITS-1:0];
      end
      if (base_count == COUNT_MAX) begin
         new_count = COUNT_MAX;
         new_sat   = 1'b1;
      end else begin
         new_count = base_count + COUNT_BITS'(1);
      end

      // The closed group is the last word unless this record also ends the data.
      old_res = make_result(key_ff, sum_ff, count_ff, sat_ff, !stage_data.closes);
      new_res = make_result(stage_data.key, new_sum, new_count, new_sat, 1'b1);

      push.words = take ? (2'(close_old) + 2'(stage_data.closes)) : 2'd0;
      push.word0 = close_old ? old_res : new_res;
      push.word1 = new_res;

      open_in  = open_ff;
      key_in   = key_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      if (take) begin
         if (stage_data.closes) begin
            open_in  = 1'b0;
            key_in   = '0;
            sum_in   = '0;
            count_in = '0;
            sat_in   = 1'b0;
         end else begin
            open_in  = 1'b1;
            key_in   = stage_data.key;
            sum_in   = new_sum;
            count_in = new_count;
            sat_in   = new_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         key_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         open_ff  <= open_in;
         key_ff   <= key_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         sat_ff   <= sat_in;
      end
   end

   `SGSC_ASSERT_IMPLIES(a_sat_pinned, clock, reset, sat_ff,
      (sum_ff == SUM_MAX) || (count_ff == COUNT_MAX))
   `SGSC_ASSERT_IMPLIES(a_closed_clear, clock, reset, !open_ff,
      (sum_ff == '0) && (count_ff == '0) && !sat_ff)
   `SGSC_ASSERT_IMPLIES(a_open_counted, clock, reset, open_ff, count_ff != '0)

endmodule
`default_nettype wire

// ===== sv/sgsc_result_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgsc_result_fifo
// Four-word result queue taking up to two words a cycle and giving one.
// ----------------------------------------------------------------------------
module sgsc_result_fifo
   import sgsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   output      logic       room,
   output      logic       out_valid,
   input  wire logic       out_ready,
   output      result_type out_word
);

`include "sorted_group_sum_count_macros.svh"

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   result_type            entry_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_next;
   logic                  pop;

   // Room for two words is judged on the stored count alone, so the ready
   // path from the result side does not reach the input side.
   assign room      = count_ff <= CNT_BITS'(FIFO_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_word  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.words);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push.words) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.words != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.words == 2'd2) begin
         entry_ff[wr_next] <= push.word1;
      end
   end

   `SGSC_ASSERT_ALWAYS(a_fifo_bound, clock, reset,
      count_ff <= CNT_BITS'(FIFO_DEPTH))
   `SGSC_ASSERT_ALWAYS(a_fifo_ptrs, clock, reset,
      PTR_BITS'(wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_BITS-1:0])

endmodule
`default_nettype wire

// ===== sv/sorted_group_sum_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_group_sum_count
// Path: the input register holds each record until the accumulator takes it and
// writes its results into the output queue; one record per cycle is taken while
// the queue has room for two words. Each record yields zero, one or two words
// and the output side delivers one word per cycle from a four-word queue.
// Reset: synchronous and active high; no group is open and the queue is empty.
// ----------------------------------------------------------------------------
module sorted_group_sum_count
   import sgsc_pkg::*;
#(
   parameter int SUM_BITS   = SUM_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   // Record words.
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [103:0] req_tdata,  // record_key, price_cents, discount_pct, zero pad
   input  wire logic         req_tlast,  // final_record
   // Group result words.
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [143:0] rsp_tdata,  // group_key, group_sum, group_count, zero pad
   output      logic [0:0]   rsp_tuser,  // overflow_flag
   output      logic         rsp_tlast   // last_of_burst
);

   // The block works in three parts. The input stage registers each record
   // together with its weighted amount, price times the remaining percentage,
   // which is one narrow multiplication. The accumulator then compares the
   // record's key with the open group, closes that group when the key
   // differs, and adds the amount and one record to the sums of the current
   // group, both saturating. A record that ends the data also emits its own
   // group and leaves no group open, so such a record may give two words.
   // The result queue absorbs these bursts and holds finished words while
   // the far side stalls, so records keep flowing while it has room for two words.

   logic       stage_valid;
   stage_type  stage_data;
   logic       take;
   logic       room;
   push_type   push;
   result_type out_word;

   sgsc_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_key      (req_tdata[62:0]),
      .in_price    (req_tdata[94:63]),
      .in_discount (req_tdata[101:95]),
      .in_closes   (req_tlast),
      .take        (take),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   sgsc_accumulator #(
      .SUM_BITS   (SUM_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_accumulator (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .room        (room),
      .take        (take),
      .push        (push)
   );

   sgsc_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   // The top pad bit of the result word is always zero.
   assign rsp_tdata = {1'b0, out_word.count, out_word.sum, out_word.key};
   assign rsp_tuser = out_word.overflow;
   assign rsp_tlast = out_word.last;

endmodule
`default_nettype wire
